// File: hdl/bmp_pkg.sv
// Shared types and constants for the BMP to RGB565 converter.
package bmp_pkg;

  // Coordinate and byte widths
  localparam int COORD_W = 12;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int POS_W = 32;

  // Default image dimension limit
  localparam int MAX_DIM_DEF = 4096;

  // Event queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Header byte positions at which a field completes
  localparam logic [POS_W-1:0] POS_SIGNATURE = 32'd1;
  localparam logic [POS_W-1:0] POS_OFFSET = 32'd13;
  localparam logic [POS_W-1:0] POS_WIDTH = 32'd21;
  localparam logic [POS_W-1:0] POS_HEIGHT = 32'd25;
  localparam logic [POS_W-1:0] POS_PLANES = 32'd27;
  localparam logic [POS_W-1:0] POS_BPP = 32'd29;
  localparam logic [POS_W-1:0] POS_COMPRESS = 32'd33;

  // Header constants
  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_PLANES = 16'd1;
  localparam logic [15:0] BMP_BPP = 16'd24;
  localparam logic [POS_W-1:0] HDR_LEN = 32'd34;

  // Result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Classified event passed from the front to the back
  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [COORD_W-1:0] file_row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] height_m1;
    logic               bottom_up;
    logic               last;
  } bmp_evt_t;

endpackage

// File: hdl/bmp_interfaces.sv
// Byte and pixel stream interfaces of the BMP to RGB565 converter.
interface bmp_byte_if import bmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] file_byte;
  logic              new_file;

  modport source(output valid, file_byte, new_file, input ready);
  modport sink(input valid, file_byte, new_file, output ready);
endinterface

interface bmp_pix_if import bmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [WORD_W-1:0]  pixel_word;
  logic [COORD_W-1:0] display_row;
  logic [COORD_W-1:0] display_col;
  logic               last_pixel;

  modport source(output valid, kind, pixel_word, display_row, display_col, last_pixel,
                 input ready);
  modport sink(input valid, kind, pixel_word, display_row, display_col, last_pixel,
               output ready);
endinterface

// File: hdl/bmp_front.sv
// Front part: header parser, offset skip and pixel byte gathering.
module bmp_front import bmp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic     clk,
  input  logic     rst,
  bmp_byte_if.sink bytes,
  output logic     evt_valid,
  output bmp_evt_t evt,
  input  logic     evt_ready
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [POS_W-1:0]   field_assembler, field_assembler_next;
  logic [POS_W-1:0]   data_offset, data_offset_next;
  logic [COORD_W-1:0] width_m1, width_m1_next;
  logic [COORD_W-1:0] height_m1, height_m1_next;
  logic               bottom_up, bottom_up_next;
  logic [COORD_W-1:0] file_row, file_row_next;
  logic [COORD_W-1:0] pixel_column, pixel_column_next;
  logic [1:0]         byte_in_pixel, byte_in_pixel_next;
  logic [1:0]         padding_left, padding_left_next;
  logic [BYTE_W-1:0]  blue_hold, blue_hold_next;
  logic [BYTE_W-1:0]  green_hold, green_hold_next;

  logic               accept;
  phase_t             ph;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   fa_base;
  logic [15:0]        h16;
  logic [POS_W-1:0]   mag;
  logic [POS_W-1:0]   dim_m1;
  logic [1:0]         row_pad;
  logic               err;

  // Stall only when the queue cannot take another event
  assign bytes.ready = evt_ready;
  assign accept = bytes.valid && bytes.ready;

  // A new-file byte is parsed as header byte zero
  assign ph = bytes.new_file ? PH_HEADER : phase;
  assign pos = bytes.new_file ? '0 : byte_position;
  assign fa_base = bytes.new_file ? '0 : field_assembler;
  assign field_assembler_next = {bytes.file_byte, fa_base[POS_W-1:BYTE_W]};
  assign h16 = field_assembler_next[POS_W-1:16];
  assign mag = field_assembler_next[POS_W-1] ? (~field_assembler_next + 32'd1)
                                             : field_assembler_next;
  // Row padding of a 24-bit row is width mod 4
  assign row_pad = width_m1[1:0] + 2'd1;

  // Next-state and event classification
  always_comb begin
    phase_next = phase;
    byte_position_next = byte_position;
    data_offset_next = data_offset;
    width_m1_next = width_m1;
    height_m1_next = height_m1;
    bottom_up_next = bottom_up;
    file_row_next = file_row;
    pixel_column_next = pixel_column;
    byte_in_pixel_next = byte_in_pixel;
    padding_left_next = padding_left;
    blue_hold_next = blue_hold;
    green_hold_next = green_hold;
    evt_valid = 1'b0;
    evt = '0;
    err = 1'b0;
    dim_m1 = '0;
    case (ph)
      PH_HEADER: begin
        phase_next = PH_HEADER;
        byte_position_next = pos + 32'd1;
        file_row_next = '0;
        pixel_column_next = '0;
        byte_in_pixel_next = '0;
        padding_left_next = '0;
        case (pos)
          POS_SIGNATURE: err = (h16 != BMP_SIGNATURE);
          POS_OFFSET: begin
            data_offset_next = field_assembler_next;
            err = (field_assembler_next < HDR_LEN);
          end
          POS_WIDTH: begin
            dim_m1 = field_assembler_next - 32'd1;
            width_m1_next = dim_m1[COORD_W-1:0];
            err = (field_assembler_next == '0) ||
                  (field_assembler_next > POS_W'(MAX_DIM));
          end
          POS_HEIGHT: begin
            dim_m1 = mag - 32'd1;
            height_m1_next = dim_m1[COORD_W-1:0];
            bottom_up_next = !field_assembler_next[POS_W-1];
            err = (mag == '0) || (mag > POS_W'(MAX_DIM));
          end
          POS_PLANES: err = (h16 != BMP_PLANES);
          POS_BPP: err = (h16 != BMP_BPP);
          POS_COMPRESS: begin
            err = (field_assembler_next != '0);
            phase_next = (data_offset == HDR_LEN) ? PH_PIXEL : PH_SKIP;
          end
          default: err = 1'b0;
        endcase
        if (err) begin
          evt_valid = 1'b1;
          evt.kind = KIND_ERROR;
          phase_next = PH_DONE;
        end
      end
      PH_SKIP: begin
        byte_position_next = pos + 32'd1;
        if (byte_position_next == data_offset) begin
          phase_next = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        case (byte_in_pixel)
          2'd0: begin
            blue_hold_next = bytes.file_byte;
            byte_in_pixel_next = 2'd1;
          end
          2'd1: begin
            green_hold_next = bytes.file_byte;
            byte_in_pixel_next = 2'd2;
          end
          default: begin
            evt_valid = 1'b1;
            evt.kind = KIND_PIXEL;
            evt.red = bytes.file_byte;
            evt.green = green_hold;
            evt.blue = blue_hold;
            evt.file_row = file_row;
            evt.col = pixel_column;
            evt.height_m1 = height_m1;
            evt.bottom_up = bottom_up;
            byte_in_pixel_next = 2'd0;
            if (pixel_column == width_m1) begin
              if (file_row == height_m1) begin
                evt.last = 1'b1;
                phase_next = PH_DONE;
              end else if (row_pad != 2'd0) begin
                padding_left_next = row_pad;
                phase_next = PH_PAD;
              end else begin
                pixel_column_next = '0;
                file_row_next = file_row + 1'b1;
              end
            end else begin
              pixel_column_next = pixel_column + 1'b1;
            end
          end
        endcase
      end
      PH_PAD: begin
        padding_left_next = padding_left - 2'd1;
        if (padding_left_next == 2'd0) begin
          pixel_column_next = '0;
          file_row_next = file_row + 1'b1;
          phase_next = PH_PIXEL;
        end
      end
      default: phase_next = PH_DONE;
    endcase
    // Only an accepted byte produces an event
    if (!accept) begin
      evt_valid = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_position <= '0;
      field_assembler <= '0;
      file_row <= '0;
      pixel_column <= '0;
      byte_in_pixel <= '0;
      padding_left <= '0;
    end else if (accept) begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      field_assembler <= field_assembler_next;
      file_row <= file_row_next;
      pixel_column <= pixel_column_next;
      byte_in_pixel <= byte_in_pixel_next;
      padding_left <= padding_left_next;
    end
  end

  // Header fields and held colour bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      data_offset <= data_offset_next;
      width_m1 <= width_m1_next;
      height_m1 <= height_m1_next;
      bottom_up <= bottom_up_next;
      blue_hold <= blue_hold_next;
      green_hold <= green_hold_next;
    end
  end

endmodule

// File: hdl/bmp_queue.sv
// Short event queue between the parser and the formatter.
module bmp_queue import bmp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  input  bmp_evt_t wr_data,
  output logic     wr_ready,
  output logic     rd_valid,
  output bmp_evt_t rd_data,
  input  logic     rd_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bmp_evt_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data = slots[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hdl/bmp_back.sv
// Back part: RGB565 packing, row orientation and output register.
module bmp_back import bmp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       evt_valid,
  input  bmp_evt_t   evt,
  output logic       evt_ready,
  bmp_pix_if.source  pixels
);

  logic [WORD_W-1:0]  c565;
  logic [COORD_W-1:0] drow;
  logic               load;

  // Output register frees as soon as its request is taken
  assign evt_ready = !pixels.valid || pixels.ready;
  assign load = evt_valid && evt_ready;

  // 5-6-5 packing and display row
  assign c565 = {evt.red[7:3], evt.green[7:2], evt.blue[7:3]};
  assign drow = evt.bottom_up ? (evt.height_m1 - evt.file_row) : evt.file_row;

  // Output request valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (evt_ready) begin
      pixels.valid <= evt_valid;
    end
  end

  // Output payload; an error carries zero fields
  always_ff @(posedge clk) begin
    if (load) begin
      pixels.kind <= evt.kind;
      if (evt.kind == KIND_ERROR) begin
        pixels.pixel_word <= '0;
        pixels.display_row <= '0;
        pixels.display_col <= '0;
        pixels.last_pixel <= 1'b0;
      end else begin
        pixels.pixel_word <= {c565[7:0], c565[15:8]};
        pixels.display_row <= drow;
        pixels.display_col <= evt.col;
        pixels.last_pixel <= evt.last;
      end
    end
  end

endmodule

// File: hdl/bmp24_to_rgb565_converter.sv
// Top level of the 24-bit BMP to RGB565 stream converter.
// Takes one file byte per cycle on the bytes channel, parses and checks the 34-byte BMP
// header, skips to the pixel data and emits one byte-swapped RGB565 pixel per three data
// bytes, with its display row (reversed for bottom-up files) and column; a bad header,
// zero size, size above MAX_DIM or data offset below 34 gives a single error request and
// the rest of the file is ignored until a byte marked new_file. Throughput is one byte per
// cycle, set by the parser, which decides every byte combinationally from counters and
// small compares; a result request is registered first in the two-entry event queue and
// then in the output register. The bytes channel stalls only when that queue is full
// because the pixels channel is being held.
module bmp24_to_rgb565_converter import bmp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bmp_byte_if.sink   bytes,
  bmp_pix_if.source  pixels
);

  logic     fr_valid;
  logic     fr_ready;
  bmp_evt_t fr_evt;
  logic     bk_valid;
  logic     bk_ready;
  bmp_evt_t bk_evt;

  bmp_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .evt_valid(fr_valid),
    .evt      (fr_evt),
    .evt_ready(fr_ready)
  );

  bmp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(fr_valid),
    .wr_data (fr_evt),
    .wr_ready(fr_ready),
    .rd_valid(bk_valid),
    .rd_data (bk_evt),
    .rd_ready(bk_ready)
  );

  bmp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .evt_valid(bk_valid),
    .evt      (bk_evt),
    .evt_ready(bk_ready),
    .pixels   (pixels)
  );

endmodule

// File: dv/bmp24_to_rgb565_converter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the BMP to RGB565 converter: file streams in, predicted pixels out.
module bmp24_to_rgb565_converter_tb;
  import bmp_pkg::*;

  localparam logic [31:0] IMG_LIMIT = MAX_DIM_DEF;
  localparam int RAND_ITEMS = 600;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int TIMEOUT_NS = 4_000_000;
  localparam int BURST_FROM = 1000;
  localparam int BURST_TO = 1800;

  typedef enum logic [2:0] {PH_HEADER, PH_SKIP, PH_PIXEL, PH_PAD, PH_DONE} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       mark;
    logic       drain;
  } byte_req_t;

  typedef struct packed {
    logic               kind;
    logic [WORD_W-1:0]  pixel_word;
    logic [COORD_W-1:0] display_row;
    logic [COORD_W-1:0] display_col;
    logic               last_pixel;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst;

  bmp_byte_if bytes_if();
  bmp_pix_if  pix_if();

  bmp24_to_rgb565_converter #(.MAX_DIM(MAX_DIM_DEF)) DUT (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .pixels (pix_if)
  );

  always #4 clk = ~clk;

  // Stimulus backlog and predicted results
  byte_req_t     byte_backlog[$];
  pixel_result_t due_results[$];
  int            queued_items = 0;
  bit            drain_next = 1'b0;
  int            fail_count = 0;
  int            results_seen = 0;
  int            cycle_no = 0;

  // Parser state of the predictor
  parse_phase_t       ph;
  logic [31:0]        byte_pos;
  logic [31:0]        field_asm;
  logic [31:0]        data_off;
  logic [12:0]        img_w;
  logic [12:0]        img_h;
  logic               bottom_up;
  logic [COORD_W-1:0] file_row;
  logic [COORD_W-1:0] pix_col;
  logic [1:0]         byte_in_pix;
  logic [1:0]         pad_left;
  logic [7:0]         blue_hold;
  logic [7:0]         green_hold;

  task automatic clear_parser();
    ph = PH_HEADER;
    byte_pos = '0;
    field_asm = '0;
    data_off = '0;
    img_w = '0;
    img_h = '0;
    bottom_up = 1'b1;
    file_row = '0;
    pix_col = '0;
    byte_in_pix = '0;
    pad_left = '0;
    blue_hold = '0;
    green_hold = '0;
  endtask

  // Predicts the result, if any, of one accepted file byte
  task automatic convert_byte(input logic [7:0] v, input logic mark);
    logic [31:0]   pos;
    logic [31:0]   w32;
    logic [31:0]   mag;
    logic [31:0]   drow;
    logic [15:0]   h16;
    logic [15:0]   c565;
    logic          bad;
    logic          produce;
    pixel_result_t res;
    bad = 1'b0;
    produce = 1'b0;
    res = '0;
    if (mark) clear_parser();
    case (ph)
      PH_HEADER: begin
        pos = byte_pos;
        byte_pos = pos + 32'd1;
        field_asm = {v, field_asm[31:8]};
        w32 = field_asm;
        h16 = field_asm[31:16];
        case (pos)
          POS_SIGNATURE: bad = (h16 != BMP_SIGNATURE);
          POS_OFFSET: begin
            data_off = w32;
            bad = (w32 < HDR_LEN);
          end
          POS_WIDTH: begin
            bad = (w32 == 32'd0 || w32 > IMG_LIMIT);
            if (!bad) img_w = w32[12:0];
          end
          POS_HEIGHT: begin
            // negative height: rows stored top-down
            if (w32[31]) begin
              mag = -w32;
              bottom_up = 1'b0;
            end else begin
              mag = w32;
              bottom_up = 1'b1;
            end
            bad = (mag == 32'd0 || mag > IMG_LIMIT);
            if (!bad) img_h = mag[12:0];
          end
          POS_PLANES: bad = (h16 != BMP_PLANES);
          POS_BPP: bad = (h16 != BMP_BPP);
          POS_COMPRESS: begin
            bad = (w32 != 32'd0);
            if (!bad) ph = (data_off == HDR_LEN) ? PH_PIXEL : PH_SKIP;
          end
          default: ;
        endcase
        if (bad) begin
          produce = 1'b1;
          res.kind = KIND_ERROR;
          ph = PH_DONE;
        end
      end
      PH_SKIP: begin
        pos = byte_pos;
        byte_pos = pos + 32'd1;
        if (pos + 32'd1 == data_off) ph = PH_PIXEL;
      end
      PH_PIXEL: begin
        case (byte_in_pix)
          2'd0: begin
            blue_hold = v;
            byte_in_pix = 2'd1;
          end
          2'd1: begin
            green_hold = v;
            byte_in_pix = 2'd2;
          end
          default: begin
            c565 = {v[7:3], green_hold[7:2], blue_hold[7:3]};
            drow = 32'(img_h) - 32'd1 - 32'(file_row);
            produce = 1'b1;
            res.kind = KIND_PIXEL;
            res.pixel_word = {c565[7:0], c565[15:8]};
            res.display_row = bottom_up ? drow[COORD_W-1:0] : file_row;
            res.display_col = pix_col;
            byte_in_pix = 2'd0;
            if (32'(pix_col) + 32'd1 >= 32'(img_w)) begin
              if (32'(file_row) + 32'd1 >= 32'(img_h)) begin
                res.last_pixel = 1'b1;
                ph = PH_DONE;
              end else if (img_w[1:0] != 2'd0) begin
                pad_left = img_w[1:0];
                ph = PH_PAD;
              end else begin
                pix_col = '0;
                file_row = file_row + 1'b1;
              end
            end else begin
              pix_col = pix_col + 1'b1;
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) begin
          pix_col = '0;
          file_row = file_row + 1'b1;
          ph = PH_PIXEL;
        end
      end
      default: ;
    endcase
    if (produce) due_results.push_back(res);
  endtask

  // Stimulus helpers
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic mark);
    byte_backlog.push_back('{data: b, mark: mark, drain: drain_next});
    drain_next = 1'b0;
    queued_items++;
  endtask

  // filler bytes; not counted in queued_items
  task automatic push_junk(input int n);
    for (int i = 0; i < n; i++) byte_backlog.push_back('{data: pick_byte(), mark: 1'b0, drain: 1'b0});
  endtask

  task automatic push_le(input logic [31:0] val, input int n, input logic mark);
    for (int i = 0; i < n; i++) push_byte(val[8*i +: 8], mark && (i == 0));
  endtask

  task automatic push_header(input logic mark, input logic [15:0] sig, input logic [31:0] offs,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] planes, input logic [15:0] bpp,
                             input logic [31:0] comp);
    push_le(32'(sig), 2, mark);
    push_le($urandom, 4, 1'b0);    // file size
    push_le($urandom, 4, 1'b0);    // creator
    push_le(offs, 4, 1'b0);
    push_le($urandom, 4, 1'b0);    // DIB size
    push_le(w, 4, 1'b0);
    push_le(h, 4, 1'b0);
    push_le(32'(planes), 2, 1'b0);
    push_le(32'(bpp), 2, 1'b0);
    push_le(comp, 4, 1'b0);
  endtask

  // gap up to the data offset, then rows with padding; keep < 0 sends all
  task automatic push_body(input int gap, input int w, input int hmag, input int keep);
    int left;
    int row_len;
    left = keep;
    row_len = 3 * w + (w % 4);
    for (int i = 0; i < gap && left != 0; i++) begin
      push_byte(pick_byte(), 1'b0);
      left--;
    end
    for (int r = 0; r < hmag && left != 0; r++)
      for (int k = 0; k < row_len && left != 0; k++) begin
        push_byte(pick_byte(), 1'b0);
        left--;
      end
  endtask

  task automatic push_image(input logic mark, input int offs, input int w, input int h,
                            input int keep);
    push_header(mark, BMP_SIGNATURE, offs, w, h, BMP_PLANES, BMP_BPP, 32'd0);
    push_body(offs - 34, w, (h < 0) ? -h : h, keep);
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      bytes_if.valid <= 1'b0;
    end else begin
      cycle_no <= cycle_no + 1;
      if (bytes_if.valid && bytes_if.ready) convert_byte(bytes_if.file_byte, bytes_if.new_file);
      if (!bytes_if.valid || bytes_if.ready) begin
        if (byte_backlog.size() != 0 &&
            !(byte_backlog[0].drain && due_results.size() != 0) &&
            !(($urandom_range(0, 99) < 25) &&
              !(cycle_no >= BURST_FROM && cycle_no < BURST_TO))) begin
          bytes_if.valid <= 1'b1;
          bytes_if.file_byte <= byte_backlog[0].data;
          bytes_if.new_file <= byte_backlog[0].mark;
          void'(byte_backlog.pop_front());
        end else begin
          bytes_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random and long back-pressure
  pixel_result_t want;
  int            hold_left = 0;
  bit            long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      pix_if.ready <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("unexpected request: kind %0d word %h row %0d col %0d", pix_if.kind,
                 pix_if.pixel_word, pix_if.display_row, pix_if.display_col);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (pix_if.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, pix_if.kind);
            fail_count++;
          end
          if (pix_if.pixel_word !== want.pixel_word) begin
            $error("pixel_word: expected %h, got %h", want.pixel_word, pix_if.pixel_word);
            fail_count++;
          end
          if (pix_if.display_row !== want.display_row) begin
            $error("display_row: expected %0d, got %0d", want.display_row, pix_if.display_row);
            fail_count++;
          end
          if (pix_if.display_col !== want.display_col) begin
            $error("display_col: expected %0d, got %0d", want.display_col, pix_if.display_col);
            fail_count++;
          end
          if (pix_if.last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", want.last_pixel, pix_if.last_pixel);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        pix_if.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= !(($urandom_range(0, 99) < 25) &&
                          !(cycle_no >= BURST_FROM && cycle_no < BURST_TO));
      end
    end
  end

  // Timeout
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int          base;
    int          w;
    int          h;
    int          offs;
    int          keep;
    logic [15:0] sig;
    logic [15:0] planes;
    logic [15:0] bpp;
    logic [31:0] woff;
    logic [31:0] wdim;
    logic [31:0] hdim;
    logic [31:0] comp;

    rst = 1'b1;
    bytes_if.valid = 1'b0;
    bytes_if.file_byte = '0;
    bytes_if.new_file = 1'b0;
    pix_if.ready = 1'b0;

    // first file without a start mark, bottom-up, two bytes of padding per row
    push_image(1'b0, 34, 2, 2, -1);
    // top-down with a gap before the pixels, then bytes after the last pixel
    push_image(1'b1, 41, 3, -2, -1);
    push_junk(5);
    push_image(1'b1, 34, 4, 1, -1);
    push_image(1'b1, 35, 1, 3, -1);
    push_image(1'b1, 34, 3, -1, -1);
    // one failing check each, trailing bytes ignored
    push_header(1'b1, 16'h4D43, 34, 2, 2, BMP_PLANES, BMP_BPP, 32'd0);
    push_junk(3);
    push_header(1'b1, 16'h5D42, 34, 2, 2, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 33, 2, 2, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 0, 2, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 4097, 2, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 32'hFFFF_FFFF, 2, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 0, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 4097, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, -4097, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 32'h8000_0000, BMP_PLANES, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 2, 16'd0, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 2, 16'd2, BMP_BPP, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 2, BMP_PLANES, 16'd32, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 2, BMP_PLANES, 16'h0118, 32'd0);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 2, BMP_PLANES, BMP_BPP, 32'd1);
    push_header(1'b1, BMP_SIGNATURE, 34, 2, 2, BMP_PLANES, BMP_BPP, 32'h0100_0000);
    push_junk(4);
    // restart mid-header, mid-image and during an endless skip
    push_le(32'(BMP_SIGNATURE), 2, 1'b1);
    push_junk(6);
    drain_next = 1'b1;
    push_image(1'b1, 36, 5, 3, 20);
    push_header(1'b1, BMP_SIGNATURE, 32'hFFFF_FFFF, 2, 2, BMP_PLANES, BMP_BPP, 32'd0);
    push_junk(30);
    // largest sizes, each image cut short
    push_image(1'b1, 34, 4096, 1, 60);
    push_image(1'b1, 34, 1, 4096, 40);
    push_image(1'b1, 34, 2, -4096, 30);

    // random files: mostly well formed, some broken headers and noise
    base = queued_items;
    while (queued_items - base < RAND_ITEMS) begin
      if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      if ($urandom_range(0, 1) == 1) h = -h;
      offs = ($urandom_range(0, 1) == 1) ? 34 : 34 + $urandom_range(1, 12);
      case ($urandom_range(0, 99)) inside
        [0:74]: begin
          keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3 * w * 2) : -1;
          push_image($urandom_range(0, 15) != 0, offs, w, h, keep);
          if (keep < 0) push_junk($urandom_range(0, 3));
        end
        [75:91]: begin
          sig = BMP_SIGNATURE;
          woff = offs;
          wdim = w;
          hdim = h;
          planes = BMP_PLANES;
          bpp = BMP_BPP;
          comp = 32'd0;
          case ($urandom_range(0, 6))
            0: sig = sig ^ (16'h1 << $urandom_range(0, 15));
            1: woff = $urandom_range(0, 33);
            2: case ($urandom_range(0, 2))
                 0: wdim = 32'd0;
                 1: wdim = 32'd4097 + $urandom_range(0, 5000);
                 default: wdim = $urandom | 32'h8000_0000;
               endcase
            3: case ($urandom_range(0, 3))
                 0: hdim = 32'd0;
                 1: hdim = 32'd4097 + $urandom_range(0, 5000);
                 2: hdim = -(32'd4097 + $urandom_range(0, 5000));
                 default: hdim = 32'h8000_0000;
               endcase
            4: planes = planes ^ (16'h1 << $urandom_range(0, 15));
            5: bpp = bpp ^ (16'h1 << $urandom_range(0, 15));
            default: comp = 32'h1 << $urandom_range(0, 31);
          endcase
          push_header(1'b1, sig, woff, wdim, hdim, planes, bpp, comp);
          push_junk($urandom_range(0, 6));
        end
        default: begin
          push_byte(pick_byte(), 1'b1);
          push_junk($urandom_range(1, 20));
        end
      endcase
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (byte_backlog.size() != 0 || bytes_if.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/bmp_pkg.sv
hdl/bmp_interfaces.sv
hdl/bmp_front.sv
hdl/bmp_queue.sv
hdl/bmp_back.sv
hdl/bmp24_to_rgb565_converter.sv
dv/bmp24_to_rgb565_converter_tb.sv
